// ----- rtl/nearest_neighbor_scale_addresses_macros.svh -----
// assertion macros shared by the address generator
`ifndef NEAREST_NEIGHBOR_SCALE_ADDRESSES_MACROS_SVH
`define NEAREST_NEIGHBOR_SCALE_ADDRESSES_MACROS_SVH

// same-cycle implication, masked while in reset
`define NNSA_ASSERT_IMPL(label, clock, reset_n, cond, conseq) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (cond) |-> (conseq)) \
        else $error("nnsa assertion failed");

// next-cycle implication, masked while in reset
`define NNSA_ASSERT_NEXT(label, clock, reset_n, cond, conseq) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (cond) |=> (conseq)) \
        else $error("nnsa assertion failed");

`endif

// ----- rtl/nnsa_pkg.sv -----
package nnsa_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_W         = 13;
    localparam int COORD_W       = 12;
    localparam int BPP_W         = 3;
    localparam int MAX_BPP       = 4;
    localparam int PITCH_ALIGN   = 4;
    localparam int OFFSET_W      = 26;
    localparam int QUO_W         = $clog2(MAX_DIMENSION);
    localparam int NUM_W         = COORD_W + QUO_W;
    localparam int TRIAL_W       = NUM_W + 1;
    localparam int PITCH_W       = $clog2(MAX_DIMENSION * MAX_BPP) + 1;
    localparam int SRC_W         = QUO_W + PITCH_W + 1;
    localparam int DST_W         = NUM_W + BPP_W;

    localparam int DATA_W        = 32;
    localparam int ADDR_W        = 5;
    localparam int REG_IDX_W     = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PIXEL_BYTES   = 3'd4;

    localparam logic [DIM_W-1:0] RESET_SOURCE_WIDTH  = 13'd352;
    localparam logic [DIM_W-1:0] RESET_SOURCE_HEIGHT = 13'd288;
    localparam logic [DIM_W-1:0] RESET_TARGET_WIDTH  = 13'd352;
    localparam logic [DIM_W-1:0] RESET_TARGET_HEIGHT = 13'd288;
    localparam logic [BPP_W-1:0] RESET_PIXEL_BYTES   = 3'd3;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } coord_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] source_offset;
        logic [OFFSET_W-1:0] target_offset;
        logic                outside;
    } addr_t;

    // clamped configuration as used by the datapath
    typedef struct packed {
        logic [DIM_W-1:0]   source_width;
        logic [DIM_W-1:0]   source_height;
        logic [DIM_W-1:0]   target_width;
        logic [DIM_W-1:0]   target_height;
        logic [BPP_W-1:0]   pixel_bytes;
        logic [PITCH_W-1:0] row_pitch;
    } cfg_t;

    // one item in flight through the divider stages
    typedef struct packed {
        logic [NUM_W-1:0] col_rem;
        logic [NUM_W-1:0] row_rem;
        logic [QUO_W-1:0] col_quo;
        logic [QUO_W-1:0] row_quo;
        logic [NUM_W-1:0] target_lin;
        logic             outside;
    } div_data_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_DIMENSION))
        begin
            r = DIM_W'(MAX_DIMENSION);
        end
        return r;
    endfunction

    function automatic logic [BPP_W-1:0] clamp_bpp(input logic [BPP_W-1:0] v);
        logic [BPP_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = BPP_W'(1);
        end
        else if (v > BPP_W'(MAX_BPP))
        begin
            r = BPP_W'(MAX_BPP);
        end
        return r;
    endfunction

endpackage

// ----- rtl/nnsa_regs.sv -----
module nnsa_regs
    import nnsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [DIM_W-1:0]     source_width_reg;
    logic [DIM_W-1:0]     source_height_reg;
    logic [DIM_W-1:0]     target_width_reg;
    logic [DIM_W-1:0]     target_height_reg;
    logic [BPP_W-1:0]     pixel_bytes_reg;
    logic [REG_IDX_W-1:0] index;
    logic                 write_en;
    logic [PITCH_W-1:0]   row_bytes;

    assign pready   = 1'b1;
    assign index    = paddr[ADDR_W-1:2];
    assign write_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= RESET_SOURCE_WIDTH;
            source_height_reg <= RESET_SOURCE_HEIGHT;
            target_width_reg  <= RESET_TARGET_WIDTH;
            target_height_reg <= RESET_TARGET_HEIGHT;
            pixel_bytes_reg   <= RESET_PIXEL_BYTES;
        end
        else if (write_en)
        begin
            case (index)
                REG_SOURCE_WIDTH:  source_width_reg  <= pwdata[DIM_W-1:0];
                REG_SOURCE_HEIGHT: source_height_reg <= pwdata[DIM_W-1:0];
                REG_TARGET_WIDTH:  target_width_reg  <= pwdata[DIM_W-1:0];
                REG_TARGET_HEIGHT: target_height_reg <= pwdata[DIM_W-1:0];
                REG_PIXEL_BYTES:   pixel_bytes_reg   <= pwdata[BPP_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_SOURCE_WIDTH:  prdata = DATA_W'(source_width_reg);
            REG_SOURCE_HEIGHT: prdata = DATA_W'(source_height_reg);
            REG_TARGET_WIDTH:  prdata = DATA_W'(target_width_reg);
            REG_TARGET_HEIGHT: prdata = DATA_W'(target_height_reg);
            REG_PIXEL_BYTES:   prdata = DATA_W'(pixel_bytes_reg);
            default:           prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.source_width  = clamp_dim(source_width_reg);
        cfg.source_height = clamp_dim(source_height_reg);
        cfg.target_width  = clamp_dim(target_width_reg);
        cfg.target_height = clamp_dim(target_height_reg);
        cfg.pixel_bytes   = clamp_bpp(pixel_bytes_reg);
        row_bytes         = PITCH_W'(cfg.source_width) * PITCH_W'(cfg.pixel_bytes);
        // round up to the pitch alignment
        cfg.row_pitch     = (row_bytes + PITCH_W'(PITCH_ALIGN - 1))
                            & ~PITCH_W'(PITCH_ALIGN - 1);
    end

endmodule

// ----- rtl/nnsa_div_pipe.sv -----
module nnsa_div_pipe
    import nnsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  cfg_t      cfg,
    input  logic      din_valid,
    input  div_data_t din,
    output logic      dout_valid,
    output div_data_t dout
);

    // one quotient bit per stage for both the column and the row quotient
    div_data_t stage_reg [QUO_W];
    logic      valid_reg [QUO_W];

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        localparam int BIT = QUO_W - 1 - s;

        div_data_t        prev;
        logic             prev_valid;
        div_data_t        stage_next;
        logic [TRIAL_W-1:0] col_trial;
        logic [TRIAL_W-1:0] row_trial;

        if (s == 0)
        begin : g_first
            assign prev       = din;
            assign prev_valid = din_valid;
        end
        else
        begin : g_rest
            assign prev       = stage_reg[s-1];
            assign prev_valid = valid_reg[s-1];
        end

        always_comb
        begin
            stage_next = prev;
            col_trial  = {1'b0, prev.col_rem} - (TRIAL_W'(cfg.target_width) << BIT);
            row_trial  = {1'b0, prev.row_rem} - (TRIAL_W'(cfg.target_height) << BIT);
            // no borrow means the shifted divisor fits
            if (!col_trial[TRIAL_W-1])
            begin
                stage_next.col_rem      = col_trial[NUM_W-1:0];
                stage_next.col_quo[BIT] = 1'b1;
            end
            if (!row_trial[TRIAL_W-1])
            begin
                stage_next.row_rem      = row_trial[NUM_W-1:0];
                stage_next.row_quo[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[s] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                stage_reg[s] <= stage_next;
            end
        end
    end

    assign dout_valid = valid_reg[QUO_W-1];
    assign dout       = stage_reg[QUO_W-1];

endmodule

// ----- rtl/nnsa_offset.sv -----
module nnsa_offset
    import nnsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  cfg_t      cfg,
    input  logic      din_valid,
    input  div_data_t din,
    output logic      addr_valid,
    output addr_t     addr
);

    logic [SRC_W-1:0] source_sum;
    logic [DST_W-1:0] target_sum;
    addr_t            addr_next;
    logic             addr_valid_reg;
    addr_t            addr_reg;

    always_comb
    begin
        source_sum = SRC_W'(din.row_quo) * SRC_W'(cfg.row_pitch)
                     + SRC_W'(din.col_quo) * SRC_W'(cfg.pixel_bytes);
        target_sum = DST_W'(din.target_lin) * DST_W'(cfg.pixel_bytes);
        addr_next.outside = din.outside;
        if (din.outside)
        begin
            addr_next.source_offset = '0;
            addr_next.target_offset = '0;
        end
        else
        begin
            addr_next.source_offset = source_sum[OFFSET_W-1:0];
            addr_next.target_offset = target_sum[OFFSET_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            addr_valid_reg <= din_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            addr_reg <= addr_next;
        end
    end

    assign addr_valid = addr_valid_reg;
    assign addr       = addr_reg;

endmodule

// ----- rtl/nearest_neighbor_scale_addresses.sv -----
// a coordinate passes the front stage register, the quotient stages and the offset register
// throughput: one coordinate per cycle while the output is not stalled; the 12-stage quotient pipeline sets the depth
// a stalled result holds the whole pipeline, so coord_ready is low while addr_valid is high and addr_ready is low
// reset: size registers return to 352x288 -> 352x288 at 3 bytes per pixel,
// all pipeline valid bits clear
`include "nearest_neighbor_scale_addresses_macros.svh"

module nearest_neighbor_scale_addresses
    import nnsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              coord_valid,
    output logic              coord_ready,
    input  coord_t            coord,
    output logic              addr_valid,
    input  logic              addr_ready,
    output addr_t             addr
);

    cfg_t      cfg;
    logic      advance;
    div_data_t front_next;
    div_data_t front_reg;
    logic      front_valid_reg;
    logic      div_valid;
    div_data_t div_data;

    nnsa_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance     = !addr_valid || addr_ready;
    assign coord_ready = advance;

    // front stage: range check and the three products
    always_comb
    begin
        front_next.outside    = ({1'b0, coord.column} >= cfg.target_width)
                                || ({1'b0, coord.row} >= cfg.target_height);
        front_next.col_rem    = NUM_W'(coord.column) * NUM_W'(cfg.source_width);
        front_next.row_rem    = NUM_W'(coord.row) * NUM_W'(cfg.source_height);
        front_next.col_quo    = '0;
        front_next.row_quo    = '0;
        front_next.target_lin = NUM_W'(coord.row) * NUM_W'(cfg.target_width)
                                + NUM_W'(coord.column);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            front_valid_reg <= coord_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            front_reg <= front_next;
        end
    end

    nnsa_div_pipe u_div_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .cfg        (cfg),
        .din_valid  (front_valid_reg),
        .din        (front_reg),
        .dout_valid (div_valid),
        .dout       (div_data)
    );

    nnsa_offset u_offset (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .cfg        (cfg),
        .din_valid  (div_valid),
        .din        (div_data),
        .addr_valid (addr_valid),
        .addr       (addr)
    );

    `NNSA_ASSERT_IMPL(a_outside_zero, clk, rst_n, addr_valid && addr.outside, (addr.source_offset == '0) && (addr.target_offset == '0))
    `NNSA_ASSERT_IMPL(a_stall_blocks_input, clk, rst_n, addr_valid && !addr_ready, !coord_ready)
    `NNSA_ASSERT_NEXT(a_divider_drains, clk, rst_n, div_valid && advance, addr_valid)

endmodule

// ----- tb/nearest_neighbor_scale_addresses_tb.sv -----
module nearest_neighbor_scale_addresses_tb
    import nnsa_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY        = 14;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int PHASE_ITEMS    = 80;
    localparam int PHASE_COUNT    = 6;
    localparam int UNMAPPED_FIRST = 5;
    localparam logic [63:0] OFFSET_MASK = (64'd1 << OFFSET_W) - 64'd1;

    class offset_scoreboard;
        logic [DIM_W-1:0] src_w;
        logic [DIM_W-1:0] src_h;
        logic [DIM_W-1:0] dst_w;
        logic [DIM_W-1:0] dst_h;
        logic [BPP_W-1:0] bpp;
        addr_t            expected_offsets[$];
        int               mismatches;
        int               coords_seen;
        int               outside_seen;

        function new();
            src_w        = RESET_SOURCE_WIDTH;
            src_h        = RESET_SOURCE_HEIGHT;
            dst_w        = RESET_TARGET_WIDTH;
            dst_h        = RESET_TARGET_HEIGHT;
            bpp          = RESET_PIXEL_BYTES;
            mismatches   = 0;
            coords_seen  = 0;
            outside_seen = 0;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                REG_SOURCE_WIDTH:  src_w = data[DIM_W-1:0];
                REG_SOURCE_HEIGHT: src_h = data[DIM_W-1:0];
                REG_TARGET_WIDTH:  dst_w = data[DIM_W-1:0];
                REG_TARGET_HEIGHT: dst_h = data[DIM_W-1:0];
                REG_PIXEL_BYTES:   bpp   = data[BPP_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [DATA_W-1:0] read_reg(logic [REG_IDX_W-1:0] idx);
            logic [DATA_W-1:0] v;
            v = '0;
            case (idx)
                REG_SOURCE_WIDTH:  v[DIM_W-1:0] = src_w;
                REG_SOURCE_HEIGHT: v[DIM_W-1:0] = src_h;
                REG_TARGET_WIDTH:  v[DIM_W-1:0] = dst_w;
                REG_TARGET_HEIGHT: v[DIM_W-1:0] = dst_h;
                REG_PIXEL_BYTES:   v[BPP_W-1:0] = bpp;
                default: ;
            endcase
            return v;
        endfunction

        // zero reads as one, anything past the maximum reads as the maximum
        function logic [63:0] eff_dim(logic [DIM_W-1:0] v);
            if (v == '0)
            begin
                return 64'd1;
            end
            if (v > MAX_DIMENSION)
            begin
                return 64'(MAX_DIMENSION);
            end
            return 64'(v);
        endfunction

        function logic [63:0] eff_bpp(logic [BPP_W-1:0] v);
            if (v == '0)
            begin
                return 64'd1;
            end
            if (v > MAX_BPP)
            begin
                return 64'(MAX_BPP);
            end
            return 64'(v);
        endfunction

        function addr_t predict_offsets(coord_t c);
            logic [63:0] wi;
            logic [63:0] hi;
            logic [63:0] wo;
            logic [63:0] ho;
            logic [63:0] b;
            logic [63:0] col;
            logic [63:0] row;
            logic [63:0] pitch;
            logic [63:0] src;
            logic [63:0] dst;
            addr_t       r;
            wi  = eff_dim(src_w);
            hi  = eff_dim(src_h);
            wo  = eff_dim(dst_w);
            ho  = eff_dim(dst_h);
            b   = eff_bpp(bpp);
            col = 64'(c.column);
            row = 64'(c.row);
            r   = '0;
            if (col >= wo || row >= ho)
            begin
                r.outside = 1'b1;
            end
            else
            begin
                // source rows are padded to a 4 byte multiple
                pitch = (wi * b + PITCH_ALIGN - 1) / PITCH_ALIGN * PITCH_ALIGN;
                src   = ((row * hi / ho) * pitch + (col * wi / wo) * b) & OFFSET_MASK;
                dst   = ((row * wo + col) * b) & OFFSET_MASK;
                r.source_offset = src[OFFSET_W-1:0];
                r.target_offset = dst[OFFSET_W-1:0];
            end
            return r;
        endfunction

        function void note_coord(coord_t c);
            addr_t e;
            e = predict_offsets(c);
            coords_seen++;
            if (e.outside)
            begin
                outside_seen++;
            end
            expected_offsets.push_back(e);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_addr(addr_t got);
            addr_t e;
            if (expected_offsets.size() == 0)
            begin
                report_mismatch($sformatf("address transaction with nothing pending: %h", got));
                return;
            end
            e = expected_offsets.pop_front();
            if (got.source_offset !== e.source_offset)
            begin
                report_mismatch($sformatf("source_offset %0d, want %0d",
                                          got.source_offset, e.source_offset));
            end
            if (got.target_offset !== e.target_offset)
            begin
                report_mismatch($sformatf("target_offset %0d, want %0d",
                                          got.target_offset, e.target_offset));
            end
            if (got.outside !== e.outside)
            begin
                report_mismatch($sformatf("outside %b, want %b", got.outside, e.outside));
            end
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              coord_valid = 1'b0;
    logic              coord_ready;
    coord_t            coord = '0;
    logic              addr_valid;
    logic              addr_ready = 1'b0;
    addr_t             addr;

    offset_scoreboard scoreboard = new();
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               cycle_count = 0;
    int               settings_used = 1;

    nearest_neighbor_scale_addresses i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .coord_valid (coord_valid),
        .coord_ready (coord_ready),
        .coord       (coord),
        .addr_valid  (addr_valid),
        .addr_ready  (addr_ready),
        .addr        (addr)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        addr_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (coord_valid && coord_ready)
            begin
                scoreboard.note_coord(coord);
            end
            if (addr_valid && addr_ready)
            begin
                scoreboard.check_addr(addr);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task send_coord(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
        if ($urandom_range(99) < send_idle_pct)
        begin
            coord_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
        coord_valid <= 1'b1;
        coord       <= '{column: col, row: row};
        do
        begin
            @(posedge clk);
        end
        while (!coord_ready);
    endtask

    // hold the sender until every pending result is back and the pipe is empty
    task drain;
        coord_valid <= 1'b0;
        @(posedge clk);
        while (scoreboard.expected_offsets.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        scoreboard.write_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task apb_read_check(input logic [REG_IDX_W-1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== scoreboard.read_reg(idx))
        begin
            scoreboard.report_mismatch($sformatf("register %0d reads %h, want %h",
                                                 idx, prdata, scoreboard.read_reg(idx)));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task set_sizes(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                   input logic [DIM_W-1:0] tw, input logic [DIM_W-1:0] th,
                   input logic [BPP_W-1:0] b);
        logic [DATA_W-1:0] d;
        drain();
        // upper data bits are random and must be dropped
        d = $urandom; d[DIM_W-1:0] = sw; apb_write(REG_SOURCE_WIDTH, d);
        d = $urandom; d[DIM_W-1:0] = sh; apb_write(REG_SOURCE_HEIGHT, d);
        d = $urandom; d[DIM_W-1:0] = tw; apb_write(REG_TARGET_WIDTH, d);
        d = $urandom; d[DIM_W-1:0] = th; apb_write(REG_TARGET_HEIGHT, d);
        d = $urandom; d[BPP_W-1:0] = b;  apb_write(REG_PIXEL_BYTES, d);
        apb_read_check(REG_SOURCE_WIDTH);
        apb_read_check(REG_SOURCE_HEIGHT);
        apb_read_check(REG_TARGET_WIDTH);
        apb_read_check(REG_TARGET_HEIGHT);
        apb_read_check(REG_PIXEL_BYTES);
        settings_used++;
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(9))
            0:       return '0;
            1:       return DIM_W'($urandom_range(8191, MAX_DIMENSION + 1));
            2:       return DIM_W'(MAX_DIMENSION);
            3:       return DIM_W'(1);
            4:       return DIM_W'($urandom_range(16, 1));
            default: return DIM_W'($urandom_range(MAX_DIMENSION, 1));
        endcase
    endfunction

    task random_coords(input int count);
        logic [63:0]        wo;
        logic [63:0]        ho;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        wo = scoreboard.eff_dim(scoreboard.dst_w);
        ho = scoreboard.eff_dim(scoreboard.dst_h);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
            begin
                drain();
            end
            if ($urandom_range(99) < 80)
            begin
                col = COORD_W'($urandom_range(int'(wo) - 1, 0));
                row = COORD_W'($urandom_range(int'(ho) - 1, 0));
            end
            else
            begin
                col = COORD_W'($urandom);
                row = COORD_W'($urandom);
            end
            send_coord(col, row);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 25;
        recv_idle_pct = 79;

        // reset sizes, corners of the frame and just past them
        apb_read_check(REG_SOURCE_WIDTH);
        apb_read_check(REG_PIXEL_BYTES);
        send_coord(0, 0);
        send_coord(351, 287);
        send_coord(175, 143);
        send_coord(352, 0);
        send_coord(0, 288);
        send_coord(4095, 4095);

        // odd width at 3 bytes per pixel needs row padding
        set_sizes(5, 3, 7, 11, 3);
        send_coord(6, 10);
        send_coord(3, 5);
        // writes to unmapped addresses change nothing
        drain();
        for (int idx = UNMAPPED_FIRST; idx < 2 ** REG_IDX_W; idx++)
        begin
            apb_write(REG_IDX_W'(idx), '1);
        end
        send_coord(6, 10);

        // full downscale to a single pixel
        set_sizes(4096, 4096, 1, 1, 4);
        send_coord(0, 0);
        send_coord(1, 0);
        send_coord(0, 1);

        // single pixel blown up to the full frame
        set_sizes(1, 1, 4096, 4096, 1);
        send_coord(4095, 4095);
        send_coord(0, 4095);

        // out of range sizes clamp
        set_sizes(8191, 0, 4096, 4096, 7);
        send_coord(4095, 4095);
        send_coord(2048, 17);
        set_sizes(4096, 4096, 4096, 4096, 0);
        send_coord(4095, 4095);

        // largest offsets
        set_sizes(4096, 4096, 4096, 4096, 4);
        send_coord(4095, 4095);
        send_coord(4095, 0);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p / 2)
                0:
                begin
                    send_idle_pct = 25;
                    recv_idle_pct = 79;
                end
                1:
                begin
                    send_idle_pct = 79;
                    recv_idle_pct = 25;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (p == 1)
            begin
                set_sizes(4096, 4096, 4096, 4096, 4);
            end
            else if (p == 3)
            begin
                set_sizes(1, 1, 1, 1, 1);
            end
            else
            begin
                set_sizes(pick_dim(), pick_dim(), pick_dim(), pick_dim(),
                          BPP_W'($urandom_range(7, 0)));
            end
            random_coords(PHASE_ITEMS);
        end

        coord_valid <= 1'b0;
        while (scoreboard.expected_offsets.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 6) @(posedge clk);

        $display("checked %0d coordinate transactions (%0d outside the target)",
                 scoreboard.coords_seen, scoreboard.outside_seen);
        $display("over %0d size settings, sizes from 1 to beyond 4096, 0 to 7 bytes per pixel",
                 settings_used);
        if (scoreboard.mismatches == 0 && scoreboard.expected_offsets.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/nnsa_pkg.sv
rtl/nnsa_regs.sv
rtl/nnsa_div_pipe.sv
rtl/nnsa_offset.sv
rtl/nearest_neighbor_scale_addresses.sv
tb/nearest_neighbor_scale_addresses_tb.sv
